@@ design/double_to_dyadic_rational_core_assert.svh @@
// Assertion macros used by the checker file
`ifndef DOUBLE_TO_DYADIC_RATIONAL_CORE_ASSERT_SVH
`define DOUBLE_TO_DYADIC_RATIONAL_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define D2DR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define D2DR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/d2dr_pkg.sv @@
`timescale 1ns / 1ps
package d2dr_pkg;

  localparam int unsigned InW   = 64;
  localparam int unsigned NumW  = 32;
  localparam int unsigned DenW  = 32;
  localparam int unsigned OutW  = NumW + DenW;
  // fixed-point word: 31 integer bits, 55 fraction bits
  localparam int unsigned FracW = 55;
  localparam int unsigned FixW  = 86;
  localparam int unsigned ManW  = 53;

  // |x| >= 2^31 - 0.5 as a binary64 pattern with the sign cleared
  localparam logic [62:0] LimitBits = 63'h41DF_FFFF_FFE0_0000;
  localparam logic [NumW-1:0] TargetMin = 32'h4000_0000;
  localparam logic [NumW-1:0] NumMax    = 32'h7FFF_FFFF;

endpackage

@@ design/double_to_dyadic_rational_core.sv @@
`timescale 1ns / 1ps
// Channel  | Dir | Handshake                    | Payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata[63:0] value_bits
// m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata[31:0] numerator, [63:32] denominator
//
// Five register stages; one transfer per cycle while the output is not stalled.
// The last stage is the output register; all stages advance together
// when the output is empty or being taken, so a stall holds every stage.
// rst_ni clears the valid bits only; payload registers are not reset.
module double_to_dyadic_rational_core
  import d2dr_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [InW-1:0]  s_axis_tdata,   // [63:0] value_bits
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OutW-1:0] m_axis_tdata    // [31:0] numerator, [63:32] denominator
);

  logic adv;
  assign adv           = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = adv;

  logic [4:0] vld_q, vld_d;

  // ---------------- stage 1: unpack and pick scale ----------------
  logic [10:0]        ex;
  logic [51:0]        fr;
  logic signed [13:0] e_s, e0_s, sh_s;
  logic [4:0]         ka;
  logic               top;
  logic nan_d1, big_d1;

  logic               nan1_q, big1_q, neg1_q, top1_q;
  logic [ManW-1:0]    m1_q;
  logic signed [13:0] sh1_q;
  logic [4:0]         ka1_q;

  always_comb begin
    ex     = s_axis_tdata[62:52];
    fr     = s_axis_tdata[51:0];
    nan_d1 = (ex == 11'h7FF) && (fr != '0);
    big_d1 = ~nan_d1 && (s_axis_tdata[62:0] >= LimitBits);
    if (ex == '0) begin
      e_s  = -14'sd1074;
      e0_s = -14'sd1074;
    end else begin
      e_s  = $signed({3'b000, ex}) - 14'sd1075;
      e0_s = $signed({3'b000, ex}) - 14'sd1023;
    end
    top = (e0_s >= 14'sd30);
    if (top) begin
      ka = 5'd0;
    end else if (e0_s <= -14'sd2) begin
      ka = 5'd31;
    end else begin
      ka = 5'(14'sd29 - e0_s);
    end
    sh_s = e_s + $signed({9'b0, ka}) + 14'sd55;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nan1_q <= nan_d1;
      big1_q <= big_d1;
      neg1_q <= s_axis_tdata[63];
      top1_q <= top;
      m1_q   <= {(ex != '0), fr};
      sh1_q  <= sh_s;
      ka1_q  <= ka;
    end
  end

  // ---------------- stage 2: align both scales, add one half ----------------
  function automatic logic [FixW-1:0] align(input logic [ManW-1:0] m,
                                            input logic signed [13:0] sh);
    logic signed [13:0] nsh;
    logic [FixW-1:0]    w;
    nsh = -sh;
    w   = '0;
    if (sh >= 14'sd0) begin
      if (sh < 14'sd86) w = {33'b0, m} << sh[6:0];
    end else if (nsh < 14'sd53) begin
      w = {33'b0, m >> nsh[5:0]};
    end
    return w;
  endfunction

  logic [FixW-1:0] half;
  assign half = FixW'(1) << (FracW - 1);

  logic               nan2_q, big2_q, neg2_q, top2_q;
  logic [4:0]         ka2_q;
  logic [FixW-1:0]    za2_q, zb2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nan2_q <= nan1_q;
      big2_q <= big1_q;
      neg2_q <= neg1_q;
      top2_q <= top1_q;
      ka2_q  <= ka1_q;
      za2_q  <= align(m1_q, sh1_q) + half;
      zb2_q  <= align(m1_q, sh1_q + 14'sd1) + half;
    end
  end

  // ---------------- stage 3: round to double, then floor ----------------
  function automatic logic [NumW-1:0] rnd_floor(input logic [FixW-1:0] z);
    logic [6:0]       lead;
    logic [FracW:0]   sum;
    logic [FracW-1:0] hulp;
    lead = 7'd54;
    for (int i = 0; i < FixW; i++) begin
      if (z[i]) lead = 7'(i);
    end
    // half an ulp of z, carried out of the fraction means round-up to integer
    hulp = FracW'(1) << (lead - 7'd53);
    sum  = {1'b0, z[FracW-1:0]} + {1'b0, hulp};
    return {1'b0, z[FixW-1:FracW]} + NumW'(sum[FracW]);
  endfunction

  logic            nan3_q, big3_q, neg3_q, top3_q;
  logic [4:0]      ka3_q;
  logic [NumW-1:0] na3_q, nb3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nan3_q <= nan2_q;
      big3_q <= big2_q;
      neg3_q <= neg2_q;
      top3_q <= top2_q;
      ka3_q  <= ka2_q;
      na3_q  <= rnd_floor(za2_q);
      nb3_q  <= rnd_floor(zb2_q);
    end
  end

  // ---------------- stage 4: choose scale, clamp, count trailing zeros ----------------
  logic [4:0]      k_sel, tz, drop;
  logic [NumW-1:0] n_sel;

  always_comb begin
    if (top3_q || na3_q >= TargetMin || ka3_q == 5'd31) begin
      k_sel = ka3_q;
      n_sel = na3_q;
    end else begin
      k_sel = ka3_q + 5'd1;
      n_sel = nb3_q;
    end
    if (n_sel > NumMax) n_sel = NumMax;
    tz = 5'd0;
    for (int i = 30; i >= 0; i--) begin
      if (n_sel[i]) tz = 5'(i);
    end
    drop = (tz < k_sel) ? tz : k_sel;
  end

  logic            nan4_q, big4_q, neg4_q;
  logic [4:0]      k4_q, drop4_q;
  logic [NumW-1:0] n4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nan4_q  <= nan3_q;
      big4_q  <= big3_q;
      neg4_q  <= neg3_q;
      k4_q    <= k_sel;
      drop4_q <= drop;
      n4_q    <= n_sel;
    end
  end

  // ---------------- stage 5: reduce, sign, special values ----------------
  logic [NumW-1:0] num_d, nred;
  logic [DenW-1:0] den_d;

  always_comb begin
    nred = n4_q >> drop4_q;
    if (nan4_q) begin
      num_d = '0;
      den_d = '0;
    end else if (big4_q) begin
      num_d = neg4_q ? '1 : NumW'(1);
      den_d = '0;
    end else if (n4_q == '0) begin
      num_d = '0;
      den_d = DenW'(1);
    end else begin
      num_d = neg4_q ? (~nred + NumW'(1)) : nred;
      den_d = DenW'(1) << (k4_q - drop4_q);
    end
  end

  logic [OutW-1:0] out_q;

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= {den_d, num_d};
  end

  // valid bits
  assign vld_d = {vld_q[3:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  assign m_axis_tvalid = vld_q[4];
  assign m_axis_tdata  = out_q;

endmodule

@@ design/d2dr_checker.sv @@
`timescale 1ns / 1ps
`include "double_to_dyadic_rational_core_assert.svh"
module d2dr_checker
  import d2dr_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tready,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OutW-1:0] m_axis_tdata
);

  logic [NumW-1:0] num;
  logic [DenW-1:0] den;
  assign num = m_axis_tdata[NumW-1:0];
  assign den = m_axis_tdata[OutW-1:NumW];

  // a held result stays offered
  `D2DR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  // input side is blocked exactly when a result is stalled
  `D2DR_ASSERT_IMP(a_in_ready, clk_i, rst_ni, 1'b1,
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
  // special values carry only zero or a unit numerator
  `D2DR_ASSERT_IMP(a_special, clk_i, rst_ni, m_axis_tvalid && den == '0,
    num == '0 || num == NumW'(1) || num == '1)
  // finite results have a power-of-two denominator
  `D2DR_ASSERT_IMP(a_pow2, clk_i, rst_ni, m_axis_tvalid && den != '0, $onehot(den))

endmodule

bind double_to_dyadic_rational_core d2dr_checker u_d2dr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
